>>> hdl/rtp_dpk_pkg.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer package
// Shared constants and the command word passed from front end to back end.
// ----------------------------------------------------------------------------
package rtp_dpk_pkg;

    // byte positions inside an RTP packet
    localparam logic [3:0] POS_FIRST   = 4'd0;
    localparam logic [3:0] POS_MARKER  = 4'd1;
    localparam logic [3:0] POS_NAL_HDR = 4'd12;
    localparam logic [3:0] POS_FU_HDR  = 4'd13;
    localparam logic [3:0] POS_MAX     = 4'd14;

    // NAL header fields
    localparam logic [4:0] NAL_TYPE_FU_A = 5'h1c;
    localparam logic [7:0] NRI_MASK      = 8'he0;
    localparam logic [7:0] TYPE_MASK     = 8'h1f;
    localparam logic [7:0] IDR_HDR       = 8'h65;
    localparam logic [7:0] IDR_HDR_LOW   = 8'h25;

    // start code bytes
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // back end phases: data byte, then four start code bytes
    localparam logic [2:0] PH_DATA     = 3'd0;
    localparam logic [2:0] PH_SC_FIRST = 3'd1;
    localparam logic [2:0] PH_SC_LAST  = 3'd4;

    typedef struct packed {
        logic       has_byte;  // emit data
        logic [7:0] data;
        logic       has_sc;    // append 00 00 00 01
        logic       pend;      // last result ends a kept packet
    } t_cmd;

endpackage

>>> hdl/rtp_dpk_if.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer channels
// Valid/ready channels for packet bytes, stream bytes and configuration.
// ----------------------------------------------------------------------------
interface rtp_dpk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_packet;
    logic       packet_last;

    modport source (output valid, output in_byte, output first_packet,
                    output packet_last, input ready);
    modport sink   (input valid, input in_byte, input first_packet,
                    input packet_last, output ready);
endinterface

interface rtp_dpk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       run_last;

    modport source (output valid, output out_byte, output packet_end,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input packet_end,
                    input run_last, output ready);
endinterface

interface rtp_dpk_cfg_if;
    logic valid;
    logic ready;
    logic gate_enable;

    modport source (output valid, output gate_enable, input ready);
    modport sink   (input valid, input gate_enable, output ready);
endinterface

>>> hdl/rtp_h264_depacketizer.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer (FU-A aware)
// i_in carries raw RTP bytes, one per transfer, with packet_last on the final
// byte and first_packet sampled with byte 0. o_out carries the H.264 byte
// stream; run_last marks the final result of an input byte and packet_end the
// final result of a kept packet. i_cfg writes gate_enable (IDR gate); it is
// always ready and should be written only while the block is idle.
// One input byte is taken per cycle while the command queue has room; each
// byte yields 0..5 results, so the output side runs at one result per cycle
// while commands wait and the receiver is ready. A result passes from the
// front end through the queue into the output register. A start code burst
// occupies the back end for its four bytes; the queue absorbs input meanwhile.
// Reset (synchronous, active low) clears packet position, gate state, queue
// and output valid. If the receiver stalls, the output register holds, the
// queue fills, and i_in.ready drops once FIFO_DEPTH commands are waiting.
// ----------------------------------------------------------------------------
module rtp_h264_depacketizer #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtp_dpk_in_if.sink    i_in,
    rtp_dpk_out_if.source o_out,
    rtp_dpk_cfg_if.sink   i_cfg
);
    import rtp_dpk_pkg::*;

    logic accept;
    logic push;
    logic full;
    logic cmd_valid;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // input transfer whenever the queue has a free slot
    assign i_in.ready = !full;
    assign accept     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    rtp_dpk_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_byte      (i_in.in_byte),
        .i_first_packet (i_in.first_packet),
        .i_packet_last  (i_in.packet_last),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_gate     (i_cfg.gate_enable),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    rtp_dpk_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_data  (head_cmd)
    );

    // back end: one result per cycle into the output register while it is empty or being read
    rtp_dpk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_byte      (o_out.out_byte),
        .o_pend      (o_out.packet_end),
        .o_last      (o_out.run_last)
    );

endmodule

>>> hdl/rtp_dpk_front.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer front end
// Tracks packet position, FU-A state and the IDR gate; builds one command
// per packet byte that produces output.
// ----------------------------------------------------------------------------
module rtp_dpk_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_in_byte,
    input  logic              i_first_packet,
    input  logic              i_packet_last,
    input  logic              i_cfg_we,
    input  logic              i_cfg_gate,
    output logic              o_push,
    output rtp_dpk_pkg::t_cmd o_cmd
);
    import rtp_dpk_pkg::*;

    logic [3:0] r_pos,     n_pos;
    logic       r_marker,  n_marker;
    logic [7:0] r_ind,     n_ind;
    logic       r_frag,    n_frag;
    logic       r_passing, n_passing;
    logic       r_first,   n_first;
    logic       r_wait,    n_wait;
    logic       r_gate;

    logic       decide;
    logic       iframe;
    logic       cand;
    logic       gate_wait;
    logic       fu_start;
    logic [7:0] fu_hdr;

    assign fu_start = i_in_byte[7];
    assign fu_hdr   = (r_ind & NRI_MASK) | (i_in_byte & TYPE_MASK);

    always_comb begin
        n_pos     = r_pos;
        n_marker  = r_marker;
        n_ind     = r_ind;
        n_frag    = r_frag;
        n_passing = r_passing;
        n_first   = r_first;
        n_wait    = r_wait;
        decide    = 1'b0;
        iframe    = 1'b0;
        cand      = 1'b0;
        gate_wait = r_wait;
        o_cmd     = '0;
        o_cmd.data = i_in_byte;

        if (r_pos == POS_FIRST) begin
            n_first   = i_first_packet;
            n_passing = 1'b0;
            n_frag    = 1'b0;
            n_marker  = 1'b0;
            n_ind     = '0;
        end
        if (r_pos == POS_MARKER) begin
            n_marker = i_in_byte[7];
        end

        if (r_pos == POS_NAL_HDR) begin
            if (i_in_byte[4:0] == NAL_TYPE_FU_A) begin
                n_ind  = i_in_byte;
                n_frag = 1'b1;
                decide = i_packet_last;  // FU-A cut at indicator: non-IDR
            end else begin
                decide = 1'b1;
                iframe = (i_in_byte == IDR_HDR);
                cand   = 1'b1;
            end
        end else if (r_pos == POS_FU_HDR) begin
            if (r_frag) begin
                decide     = 1'b1;
                iframe     = fu_start && (fu_hdr == IDR_HDR || fu_hdr == IDR_HDR_LOW);
                cand       = fu_start;
                o_cmd.data = fu_hdr;
            end else begin
                cand = 1'b1;
            end
        end else if (r_pos >= POS_MAX) begin
            cand = 1'b1;
        end

        if (decide) begin
            if (!r_gate) begin
                n_passing = 1'b1;
            end else begin
                if (n_first && !iframe) begin
                    gate_wait = 1'b1;
                end
                if (gate_wait && iframe) begin
                    gate_wait = 1'b0;
                end
                n_wait    = gate_wait;
                n_passing = !gate_wait;
            end
        end

        o_cmd.has_byte = cand && n_passing;

        if (i_packet_last) begin
            if (r_pos >= POS_NAL_HDR && n_passing) begin
                o_cmd.has_sc = n_marker;
                o_cmd.pend   = 1'b1;
            end
            n_pos = POS_FIRST;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 4'd1;
        end
    end

    assign o_push = i_accept && (o_cmd.has_byte || o_cmd.has_sc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_FIRST;
            r_marker  <= 1'b0;
            r_ind     <= '0;
            r_frag    <= 1'b0;
            r_passing <= 1'b0;
            r_first   <= 1'b0;
            r_wait    <= 1'b0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_marker  <= n_marker;
            r_ind     <= n_ind;
            r_frag    <= n_frag;
            r_passing <= n_passing;
            r_first   <= n_first;
            r_wait    <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= 1'b0;
        end else if (i_cfg_we) begin
            r_gate <= i_cfg_gate;
        end
    end

endmodule

>>> hdl/rtp_dpk_fifo.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer command queue
// Small register queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module rtp_dpk_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rtp_dpk_pkg::t_cmd i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output rtp_dpk_pkg::t_cmd o_data
);
    import rtp_dpk_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> hdl/rtp_dpk_back.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer back end
// Expands each command into its data byte and start code into a registered
// output stage.
// ----------------------------------------------------------------------------
module rtp_dpk_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  rtp_dpk_pkg::t_cmd i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_pend,
    output logic              o_last
);
    import rtp_dpk_pkg::*;

    logic [2:0] r_phase, n_phase;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_pend;
    logic       r_last;

    logic [2:0] phase;
    logic [7:0] res_byte;
    logic       res_last;
    logic       load;

    always_comb begin
        phase = r_phase;
        if (r_phase == PH_DATA && !i_cmd.has_byte) begin
            phase = PH_SC_FIRST;
        end
        if (phase == PH_DATA) begin
            res_byte = i_cmd.data;
        end else if (phase == PH_SC_LAST) begin
            res_byte = SC_ONE;
        end else begin
            res_byte = SC_ZERO;
        end
        res_last = (phase == PH_DATA && !i_cmd.has_sc) || (phase == PH_SC_LAST);
        load     = i_cmd_valid && (!r_valid || i_ready);
        n_phase  = r_phase;
        if (load) begin
            n_phase = res_last ? PH_DATA : phase + 3'd1;
        end
    end

    assign o_pop   = load && res_last;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_pend  = r_pend;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DATA;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= res_byte;
            r_pend <= res_last && i_cmd.pend;
            r_last <= res_last;
        end
    end

endmodule

>>> hdl/rtp_dpk_checker.sv
// ----------------------------------------------------------------------------
// RTP H.264 depacketizer port checker
// Port-level properties of the output channel, bound to the top level.
// ----------------------------------------------------------------------------
module rtp_dpk_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_packet_end,
    input logic       i_out_run_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_packet_end)
            && $stable(i_out_run_last))
        else $error("stalled output changed");

    // a packet end is always the last result of its input byte
    a_pend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_packet_end |-> i_out_run_last)
        else $error("packet_end without run_last");

    // results of one input byte come out without gaps
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_run_last |=> i_out_valid)
        else $error("gap inside a result run");

    // nothing shown right after reset
    a_rst_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind rtp_h264_depacketizer rtp_dpk_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_packet_end (o_out.packet_end),
    .i_out_run_last   (o_out.run_last)
);
